@@ rtl/gdd_pkg.sv @@
// Shared widths, constants, types and calendar tables for the day difference block.
package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  // Day numbers reach about 6.1 million for the largest 14-bit year
  localparam int NUM_W   = 23;
  // Days before the month plus the day plus the leap day: at most 366
  localparam int DBD_W   = 9;
  // Quarter of the offset year minus one, at most 4195
  localparam int Q4_W    = YEAR_W - 1;
  // Quotients by 25 of values below 4681 stay below 256
  localparam int Q100_W  = 8;

  // Reciprocal of 25 scaled by 2^16, exact for dividends below 4681
  localparam int RECIP_W  = 12;
  localparam int RECIP_SH = 16;
  localparam logic [RECIP_W-1:0] RECIP_25 = 12'd2622;
  localparam int PROD_W   = Q4_W + RECIP_W;

  localparam int YEAR_OFFSET    = 400;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int LEAP_FEB_LEN   = 29;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Per-date result handed from a date unit to the top level
  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] num;
  } date_info_t;

  // Length of a month in a common year; zero for codes that are not months
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year ahead of the first of the month
  function automatic logic [DBD_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DBD_W-1:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/gdd_date_num.sv @@
// Three-stage date unit: legality check and closed-form day number of one date.
module gdd_date_num import gdd_pkg::*; (
  input  logic               clk,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  output date_info_t         info
);

  // Stage A: offset year, quarter terms and reciprocal products
  logic [YEAR_W:0]       p;
  logic [Q4_W-1:0]       q4;
  logic [YEAR_W-3:0]     yq;
  logic [PROD_W-1:0]     prod_p_nxt;
  logic [PROD_W-1:0]     prod_y_nxt;

  assign p          = {1'b0, year} + (YEAR_W + 1)'(YEAR_OFFSET - 1);
  assign q4         = p[YEAR_W:2];
  assign yq         = year[YEAR_W-1:2];
  assign prod_p_nxt = PROD_W'(q4) * PROD_W'(RECIP_25);
  assign prod_y_nxt = PROD_W'(yq) * PROD_W'(RECIP_25);

  logic [YEAR_W-1:0]  year_a_r;
  logic [MONTH_W-1:0] month_a_r;
  logic [DAY_W-1:0]   day_a_r;
  logic [Q4_W-1:0]    q4_a_r;
  logic [PROD_W-1:0]  prod_p_a_r;
  logic [PROD_W-1:0]  prod_y_a_r;

  always_ff @(posedge clk) begin
    year_a_r   <= year;
    month_a_r  <= month;
    day_a_r    <= day;
    q4_a_r     <= q4;
    prod_p_a_r <= prod_p_nxt;
    prod_y_a_r <= prod_y_nxt;
  end

  // Stage B: leap rule, legality, year base and in-year offset
  logic [Q100_W-1:0]   q100;
  logic [Q100_W-1:0]   q25y;
  logic [YEAR_W-3:0]   r25;
  logic                leap;
  logic [DAY_W-1:0]    len;
  logic                ok_nxt;
  logic [NUM_W-1:0]    base_nxt;
  logic [DBD_W-1:0]    dbd_nxt;

  assign q100 = prod_p_a_r[RECIP_SH +: Q100_W];
  assign q25y = prod_y_a_r[RECIP_SH +: Q100_W];
  // Remainder of year/4 by 25: for a multiple of four, zero means the year divides by 100
  assign r25  = year_a_r[YEAR_W-1:2] - ((YEAR_W - 2)'(q25y) * (YEAR_W - 2)'(25));
  assign leap = (year_a_r[1:0] == 2'b00) && ((r25 != '0) || (year_a_r[3:2] == 2'b00));

  always_comb begin
    len = month_len(month_a_r);
    if ((month_a_r == MONTH_FEB) && leap) begin
      len = DAY_W'(LEAP_FEB_LEN);
    end
    ok_nxt = (month_a_r inside {[MONTH_JAN:MONTH_DEC]}) && (day_a_r != '0) &&
             (day_a_r <= len);
  end

  assign base_nxt = NUM_W'(DAYS_PER_YEAR) * (NUM_W'(year_a_r) + NUM_W'(YEAR_OFFSET)) +
                    NUM_W'(q4_a_r);
  assign dbd_nxt  = days_before(month_a_r) + DBD_W'(day_a_r) +
                    DBD_W'(leap && (month_a_r > MONTH_FEB));

  logic               ok_b_r;
  logic [NUM_W-1:0]   base_b_r;
  logic [Q100_W-1:0]  q100_b_r;
  logic [DBD_W-1:0]   dbd_b_r;

  always_ff @(posedge clk) begin
    ok_b_r   <= ok_nxt;
    base_b_r <= base_nxt;
    q100_b_r <= q100;
    dbd_b_r  <= dbd_nxt;
  end

  // Stage C: fold in the century corrections
  date_info_t info_nxt;
  date_info_t info_r;

  assign info_nxt.ok  = ok_b_r;
  assign info_nxt.num = base_b_r - NUM_W'(q100_b_r) + NUM_W'(q100_b_r >> 2) +
                        NUM_W'(dbd_b_r);

  always_ff @(posedge clk) begin
    info_r <= info_nxt;
  end

  assign info = info_r;

endmodule

@@ rtl/gregorian_day_difference_top.sv @@
// Top level of the Gregorian day difference pipeline.
// Usage:
//   Drive a start date and an end date on the in_ ports and raise start. A
//   beat is taken at every rising edge with start high and busy low; busy
//   stays low, so a new date pair can enter every cycle.
//   Each beat yields one result beat: out_strobe is high for exactly one cycle
//   with out_day_count (days from start to end) and out_dates_valid. When
//   either date is illegal or start lies after end, the flag is low and the
//   count is zero. Counts beyond 22 bits saturate at all ones.
// Pipeline and throughput:
//   The result beat passes four register stages: offset and reciprocal
//   multiply, leap rule and year base, century correction, compare and
//   subtract. One beat per cycle
//   sustained.
// Reset:
//   rst_n low at a rising edge clears every valid bit; beats in flight are
//   dropped and no strobe follows them.
// Receiver:
//   The receiver cannot stall; results are shown for one cycle and must be
//   taken then.
module gregorian_day_difference_top import gdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  in_start_year,
  input  logic [MONTH_W-1:0] in_start_month,
  input  logic [DAY_W-1:0]   in_start_day,
  input  logic [YEAR_W-1:0]  in_end_year,
  input  logic [MONTH_W-1:0] in_end_month,
  input  logic [DAY_W-1:0]   in_end_day,
  output logic               out_strobe,
  output logic [COUNT_W-1:0] out_day_count,
  output logic               out_dates_valid
);

  // Never hold off a beat: every stage advances each cycle
  assign busy = 1'b0;

  // Date units for the two ends of the span
  date_info_t s_info;
  date_info_t e_info;

  gdd_date_num u_start_date (
    .clk   (clk),
    .year  (in_start_year),
    .month (in_start_month),
    .day   (in_start_day),
    .info  (s_info)
  );

  gdd_date_num u_end_date (
    .clk   (clk),
    .year  (in_end_year),
    .month (in_end_month),
    .day   (in_end_day),
    .info  (e_info)
  );

  // Carry valid bits alongside the date unit stages
  logic v_a_r, v_b_r, v_c_r;
  logic out_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r        <= 1'b0;
      v_b_r        <= 1'b0;
      v_c_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v_a_r        <= start && !busy;
      v_b_r        <= v_a_r;
      v_c_r        <= v_b_r;
      out_strobe_r <= v_c_r;
    end
  end

  // Compare, subtract and saturate
  logic [NUM_W-1:0]   diff;
  logic               valid_nxt;
  logic [COUNT_W-1:0] count_nxt;

  assign diff      = e_info.num - s_info.num;
  assign valid_nxt = s_info.ok && e_info.ok && (s_info.num <= e_info.num);

  always_comb begin
    if (!valid_nxt) begin
      count_nxt = '0;
    end else if (diff > NUM_W'(COUNT_MAX)) begin
      count_nxt = COUNT_MAX;
    end else begin
      count_nxt = diff[COUNT_W-1:0];
    end
  end

  logic [COUNT_W-1:0] day_count_r;
  logic               dates_valid_r;

  always_ff @(posedge clk) begin
    day_count_r   <= count_nxt;
    dates_valid_r <= valid_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_day_count   = day_count_r;
  assign out_dates_valid = dates_valid_r;

endmodule

@@ rtl/gdd_checker.sv @@
// Port-level checker for the day difference pipeline, bound to the top level.
module gdd_checker import gdd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [YEAR_W-1:0]  in_start_year,
  input logic [MONTH_W-1:0] in_start_month,
  input logic [DAY_W-1:0]   in_start_day,
  input logic [YEAR_W-1:0]  in_end_year,
  input logic [MONTH_W-1:0] in_end_month,
  input logic [DAY_W-1:0]   in_end_day,
  input logic               out_strobe,
  input logic [COUNT_W-1:0] out_day_count,
  input logic               out_dates_valid
);

  // Every accepted beat yields a result strobe
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_strobe)
    else $error("accepted beat produced no result strobe");

  // No strobe without an earlier accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, 4))
    else $error("result strobe without an accepted beat");

  // A rejected pair reports a zero count
  a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_dates_valid) |-> (out_day_count == '0))
    else $error("nonzero count on an invalid pair");

  // The first of a legal month against itself spans zero days
  a_same_date: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_start_year == in_end_year) &&
     (in_start_month == in_end_month) && (in_start_day == in_end_day) &&
     (in_start_month >= MONTH_JAN) && (in_start_month <= MONTH_DEC) &&
     (in_start_day == 5'd1))
    |-> ##4 (out_dates_valid && (out_day_count == '0)))
    else $error("same date did not give a zero valid span");

  // A start year after the end year is never valid
  a_year_order: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_start_year > in_end_year)) |-> ##4 !out_dates_valid)
    else $error("start after end reported valid");

endmodule

bind gregorian_day_difference_top gdd_checker u_gdd_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for the Gregorian day difference block.
module tb_top;
  import gdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PAIRS   = 1050;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned SPAN_CEILING   = 4194303;

  // Scoreboard: predicts the day span of each accepted pair and checks results in order
  class day_span_board;
    typedef struct {
      logic [COUNT_W-1:0] count;
      logic               valid;
    } span_t;

    span_t       expected_spans[$];
    int unsigned fail_count;
    int unsigned pairs_noted;
    int unsigned spans_checked;
    int unsigned legal_spans;
    int unsigned saturated_spans;

    function new();
      fail_count      = 0;
      pairs_noted     = 0;
      spans_checked   = 0;
      legal_spans     = 0;
      saturated_spans = 0;
    endfunction

    static function bit is_leap(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int unsigned month_length(int unsigned y, int unsigned m);
      int unsigned len;
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        4, 6, 9, 11:           len = 30;
        2:                     len = is_leap(y) ? LEAP_FEB_LEN : 28;
        default:               len = 0;
      endcase
      return len;
    endfunction

    static function int unsigned month_start(int unsigned m);
      int unsigned n;
      case (m)
        2:       n = 31;
        3:       n = 59;
        4:       n = 90;
        5:       n = 120;
        6:       n = 151;
        7:       n = 181;
        8:       n = 212;
        9:       n = 243;
        10:      n = 273;
        11:      n = 304;
        12:      n = 334;
        default: n = 0;
      endcase
      return n;
    endfunction

    static function bit legal_date(int unsigned y, int unsigned m, int unsigned d);
      return (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_length(y, m));
    endfunction

    // Serial day of a legal date; the year shift by 400 keeps every term positive
    static function int unsigned day_index(int unsigned y, int unsigned m, int unsigned d);
      int unsigned yy;
      int unsigned p;
      int unsigned n;
      yy = y + YEAR_OFFSET;
      p  = yy - 1;
      n  = DAYS_PER_YEAR * yy + p / 4 - p / 100 + p / 400 + month_start(m) + d;
      if (m > 2 && is_leap(y)) n = n + 1;
      return n;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      fail_count++;
    endtask

    // Predict the span of one accepted beat and queue it
    task note_pair(logic [YEAR_W-1:0] sy, logic [MONTH_W-1:0] sm, logic [DAY_W-1:0] sd,
                   logic [YEAR_W-1:0] ey, logic [MONTH_W-1:0] em, logic [DAY_W-1:0] ed);
      span_t       span;
      int unsigned a;
      int unsigned b;
      span.count = '0;
      span.valid = 1'b0;
      if (legal_date(sy, sm, sd) && legal_date(ey, em, ed)) begin
        a = day_index(sy, sm, sd);
        b = day_index(ey, em, ed);
        if (a <= b) begin
          span.valid = 1'b1;
          span.count = (b - a > SPAN_CEILING) ? COUNT_MAX : COUNT_W'(b - a);
        end
      end
      expected_spans.push_back(span);
      pairs_noted++;
    endtask

    // Compare one result beat against the oldest prediction
    task check_span(logic [COUNT_W-1:0] count, logic valid);
      span_t want;
      if (expected_spans.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: count %0d valid %b",
                                  count, valid));
      end else begin
        want = expected_spans.pop_front();
        spans_checked++;
        if (want.valid) legal_spans++;
        if (want.valid && want.count == COUNT_MAX) saturated_spans++;
        if (valid !== want.valid)
          report_mismatch($sformatf("beat %0d dates_valid %b, want %b",
                                    spans_checked, valid, want.valid));
        if (count !== want.count)
          report_mismatch($sformatf("beat %0d day_count %0d, want %0d",
                                    spans_checked, count, want.count));
      end
    endtask

    function int unsigned pending();
      return expected_spans.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [YEAR_W-1:0]  in_start_year = '0;
  logic [MONTH_W-1:0] in_start_month = '0;
  logic [DAY_W-1:0]   in_start_day = '0;
  logic [YEAR_W-1:0]  in_end_year = '0;
  logic [MONTH_W-1:0] in_end_month = '0;
  logic [DAY_W-1:0]   in_end_day = '0;
  logic               out_strobe;
  logic [COUNT_W-1:0] out_day_count;
  logic               out_dates_valid;

  day_span_board board = new();
  int unsigned   quiet_cycles = 0;
  bit            no_gap_stretch = 1'b0;

  gregorian_day_difference_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_start_year   (in_start_year),
    .in_start_month  (in_start_month),
    .in_start_day    (in_start_day),
    .in_end_year     (in_end_year),
    .in_end_month    (in_end_month),
    .in_end_day      (in_end_day),
    .out_strobe      (out_strobe),
    .out_day_count   (out_day_count),
    .out_dates_valid (out_dates_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Sample both channels at each edge; the watchdog tracks cycles with no beat
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      board.check_span(out_day_count, out_dates_valid);
    end
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
      board.note_pair(in_start_year, in_start_month, in_start_day,
                      in_end_year, in_end_month, in_end_day);
    end
    if ((out_strobe === 1'b1) || (start === 1'b1 && busy === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("gregorian_day_difference_top verification failed");
      $finish;
    end
  end

  // Present one date pair and hold it until the block takes it
  task automatic send_pair(input int unsigned sy, input int unsigned sm, input int unsigned sd,
                           input int unsigned ey, input int unsigned em, input int unsigned ed);
    start          <= 1'b1;
    in_start_year  <= YEAR_W'(sy);
    in_start_month <= MONTH_W'(sm);
    in_start_day   <= DAY_W'(sd);
    in_end_year    <= YEAR_W'(ey);
    in_end_month   <= MONTH_W'(em);
    in_end_day     <= DAY_W'(ed);
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Drop start for a while and scramble the idle inputs
  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      start          <= 1'b0;
      in_start_year  <= YEAR_W'($urandom);
      in_start_month <= MONTH_W'($urandom);
      in_start_day   <= DAY_W'($urandom);
      in_end_year    <= YEAR_W'($urandom);
      in_end_month   <= MONTH_W'($urandom);
      in_end_day     <= DAY_W'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int unsigned next_gap();
    int unsigned r;
    if (no_gap_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Century and leap boundaries plus the field extremes
  function automatic int unsigned corner_year();
    case ($urandom_range(0, 13))
      0:       return 0;
      1:       return 1;
      2:       return 4;
      3:       return 100;
      4:       return 200;
      5:       return 400;
      6:       return 1600;
      7:       return 1900;
      8:       return 2000;
      9:       return 2024;
      10:      return 2100;
      11:      return 9999;
      12:      return 10000;
      default: return 16383;
    endcase
  endfunction

  task automatic rand_date(input bit wide, output int unsigned y, output int unsigned m,
                           output int unsigned d);
    int unsigned len;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0)    y = corner_year();
    else if (wide) y = $urandom_range(0, 16383);
    else           y = $urandom_range(1, 9999);
    m   = $urandom_range(1, 12);
    len = day_span_board::month_length(y, m);
    r   = $urandom_range(0, 7);
    if (r == 0)      d = 1;
    else if (r == 1) d = len;
    else             d = $urandom_range(1, len);
  endtask

  // Break one date of a pair: bad month code, day zero or a day past month end
  task automatic spoil_date(inout int unsigned y, inout int unsigned m, inout int unsigned d);
    int unsigned len;
    case ($urandom_range(0, 2))
      0: m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
      1: d = 0;
      default: begin
        len = day_span_board::month_length(y, m);
        if (len >= 31) d = 0;
        else           d = $urandom_range(len + 1, 31);
      end
    endcase
  endtask

  task automatic make_pair(output int unsigned sy, output int unsigned sm, output int unsigned sd,
                           output int unsigned ey, output int unsigned em, output int unsigned ed);
    int unsigned pick;
    int unsigned len;
    int unsigned t;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // Ordered legal pair, often close together
      rand_date(1'b0, sy, sm, sd);
      case ($urandom_range(0, 3))
        0: begin
          ey = sy; em = sm;
          ed = $urandom_range(1, day_span_board::month_length(ey, em));
        end
        1: begin
          ey = sy; em = $urandom_range(1, 12);
          ed = $urandom_range(1, day_span_board::month_length(ey, em));
        end
        2: begin
          ey = sy + $urandom_range(0, 3); em = $urandom_range(1, 12);
          ed = $urandom_range(1, day_span_board::month_length(ey, em));
        end
        default: rand_date(1'b0, ey, em, ed);
      endcase
      if (day_span_board::day_index(sy, sm, sd) > day_span_board::day_index(ey, em, ed)) begin
        t = sy; sy = ey; ey = t;
        t = sm; sm = em; em = t;
        t = sd; sd = ed; ed = t;
      end
    end else if (pick < 70) begin
      // Legal dates over the whole year field, either order
      rand_date(1'b1, sy, sm, sd);
      rand_date(1'b1, ey, em, ed);
    end else if (pick < 85) begin
      rand_date(1'b0, sy, sm, sd);
      rand_date(1'b0, ey, em, ed);
      if ($urandom_range(0, 1) == 0) spoil_date(sy, sm, sd);
      else                           spoil_date(ey, em, ed);
    end else if (pick < 95) begin
      // February ends around leap and century years
      sy = corner_year(); sm = MONTH_FEB; sd = $urandom_range(27, 30);
      rand_date(1'b0, ey, em, ed);
      if ($urandom_range(0, 1) == 0) begin
        t = sy; sy = ey; ey = t;
        t = sm; sm = em; em = t;
        t = sd; sd = ed; ed = t;
      end
    end else begin
      sy = $urandom_range(0, 16383); sm = $urandom_range(0, 15); sd = $urandom_range(0, 31);
      ey = $urandom_range(0, 16383); em = $urandom_range(0, 15); ed = $urandom_range(0, 31);
    end
  endtask

  initial begin
    int unsigned sy, sm, sd, ey, em, ed;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners
    send_pair(2024, 3, 15, 2024, 3, 15);           hold_off(next_gap());
    send_pair(1, 1, 1, 9999, 12, 31);              hold_off(next_gap());
    send_pair(0, 1, 1, 16383, 12, 31);             hold_off(next_gap());
    send_pair(9999, 12, 31, 1, 1, 1);              hold_off(next_gap());
    send_pair(2024, 1, 2, 2024, 1, 1);             hold_off(next_gap());
    send_pair(2020, 0, 10, 2021, 5, 5);            hold_off(next_gap());
    send_pair(2020, 13, 10, 2021, 5, 5);           hold_off(next_gap());
    send_pair(2020, 5, 5, 2021, 15, 10);           hold_off(next_gap());
    send_pair(2020, 5, 0, 2021, 5, 5);             hold_off(next_gap());
    send_pair(2020, 4, 31, 2021, 5, 5);            hold_off(next_gap());
    send_pair(2000, 2, 29, 2000, 3, 1);            hold_off(next_gap());
    send_pair(1900, 2, 29, 1900, 3, 1);            hold_off(next_gap());
    send_pair(2024, 2, 29, 2025, 2, 28);           hold_off(next_gap());
    send_pair(2023, 2, 29, 2023, 3, 1);            hold_off(next_gap());
    send_pair(0, 2, 29, 0, 12, 31);                hold_off(next_gap());
    send_pair(2024, 1, 31, 2024, 2, 1);            hold_off(next_gap());
    send_pair(1999, 12, 31, 2000, 1, 1);           hold_off(next_gap());
    send_pair(16383, 15, 31, 16383, 15, 31);       hold_off(next_gap());
    send_pair(16383, 12, 31, 16383, 12, 31);       hold_off(next_gap());
    send_pair(0, 1, 1, 0, 1, 1);                   hold_off(next_gap());
    send_pair(1, 1, 1, 16383, 12, 31);             hold_off(next_gap());
    send_pair(2100, 2, 28, 2100, 3, 1);            hold_off(next_gap());

    for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 64 == 0) no_gap_stretch = ($urandom_range(0, 3) == 0);
      make_pair(sy, sm, sd, ey, em, ed);
      send_pair(sy, sm, sd, ey, em, ed);
      hold_off(next_gap());
    end
    start <= 1'b0;

    // Drain the pipeline
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d predictions never matched", board.pending()));

    $display("Covered %0d date pairs: %0d legal spans, %0d rejected, %0d saturated.",
             board.pairs_noted, board.legal_spans,
             board.spans_checked - board.legal_spans, board.saturated_spans);
    if (board.fail_count == 0) begin
      $display("gregorian_day_difference_top verification clean");
    end else begin
      $display("gregorian_day_difference_top verification failed");
    end
    $finish;
  end

endmodule

@@ gregorian_day_difference_top.f @@
rtl/gdd_pkg.sv
rtl/gdd_date_num.sv
rtl/gregorian_day_difference_top.sv
rtl/gdd_checker.sv
sim/tb_top.sv
